/* rtl/core/uwsa_pkg.sv */
// Shared constants, types and helpers for the unaligned word store access block.
`default_nettype none

package uwsa_pkg;

  localparam int STORE_WORDS = 4096;
  localparam int IDX_W       = $clog2(STORE_WORDS);
  localparam int WORD_W      = 32;
  localparam int OFS_W       = WORD_W - 2;

  localparam logic [1:0] SIZE_BYTE = 2'd0;
  localparam logic [1:0] SIZE_HALF = 2'd1;
  localparam logic [1:0] SIZE_WORD = 2'd2;

  localparam logic ACT_READ  = 1'b0;
  localparam logic ACT_WRITE = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic capture;   // accept beat: register item, read low word
    logic clr_wr;    // clearing pass: zero one word
    logic wr_lo;     // write patched low word
    logic rd_hi;     // read next word of a straddling access
    logic wr_hi;     // write patched high word
    logic load_out;  // load result register
  } uwsa_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_last;
    logic is_write;
    logic straddle;
    logic bad;
  } uwsa_status_t;

  function automatic logic [WORD_W-1:0] size_mask(input logic [1:0] code);
    logic [WORD_W-1:0] m;
    case (code)
      SIZE_BYTE: m = 32'h0000_00FF;
      SIZE_HALF: m = 32'h0000_FFFF;
      default:   m = 32'hFFFF_FFFF;  // word, unused code too
    endcase
    return m;
  endfunction

  function automatic logic straddles(input logic [1:0] code, input logic [1:0] lane);
    logic s;
    case (code)
      SIZE_BYTE: s = 1'b0;
      SIZE_HALF: s = (lane == 2'd3);
      default:   s = (lane != 2'd0);
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/uwsa_in_if.sv */
// Request channel: valid/ready with one access per beat.
`default_nettype none

interface uwsa_in_if
  import uwsa_pkg::*;
;
  logic              valid;
  logic              ready;
  logic              action;
  logic [1:0]        size_code;
  logic [WORD_W-1:0] address;
  logic [WORD_W-1:0] write_data;

  modport source (output valid, action, size_code, address, write_data, input ready);
  modport sink   (input valid, action, size_code, address, write_data, output ready);
endinterface

`default_nettype wire

/* rtl/core/uwsa_out_if.sv */
// Result channel: valid/ready with one result per beat.
`default_nettype none

interface uwsa_out_if
  import uwsa_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] read_data;
  logic              out_of_range;

  modport source (output valid, read_data, out_of_range, input ready);
  modport sink   (input valid, read_data, out_of_range, output ready);
endinterface

`default_nettype wire

/* rtl/core/uwsa_datapath.sv */
// Datapath: word store, address decode, lane merge/patch and result register.
`default_nettype none

module uwsa_datapath
  import uwsa_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [WORD_W-1:0] cfg_wdata,
  input  wire logic              in_action,
  input  wire logic [1:0]        in_size_code,
  input  wire logic [WORD_W-1:0] in_address,
  input  wire logic [WORD_W-1:0] in_write_data,
  input  wire uwsa_cmd_t         cmd,
  output uwsa_status_t           status,
  output logic [WORD_W-1:0]      out_read_data,
  output logic                   out_out_of_range
);

  logic [WORD_W-1:0] mem [STORE_WORDS];
  logic [WORD_W-1:0] rdata_r;

  logic [WORD_W-1:0] base_r;
  logic [IDX_W-1:0]  clr_cnt_r;

  logic              act_r;
  logic [1:0]        size_r;
  logic [1:0]        lane_r;
  logic [WORD_W-1:0] data_r;
  logic [IDX_W-1:0]  idx_r;
  logic              straddle_r;
  logic              bad_r;
  logic [WORD_W-1:0] lo_r;
  logic [WORD_W-1:0] res_r;
  logic              err_r;

  // decode of the incoming beat
  logic [WORD_W-1:0] offset;
  logic [OFS_W-1:0]  w_full;
  logic              in_straddle;
  logic              in_bad;

  assign offset      = in_address - {base_r[WORD_W-1:2], 2'b00};
  assign w_full      = offset[WORD_W-1:2];
  assign in_straddle = straddles(in_size_code, in_address[1:0]);
  assign in_bad      = (w_full >= OFS_W'(STORE_WORDS)) ||
                       (in_straddle && (w_full == OFS_W'(STORE_WORDS - 1)));

  // lane arithmetic on the registered item
  logic [WORD_W-1:0] mask;
  logic [WORD_W-1:0] dmask;
  logic [4:0]        sh;
  logic [5:0]        hs;
  logic [WORD_W-1:0] lo_patch;
  logic [WORD_W-1:0] hi_patch;
  logic [WORD_W-1:0] rd_single;
  logic [WORD_W-1:0] rd_merged;
  logic [IDX_W-1:0]  idx_hi;

  assign mask      = size_mask(size_r);
  assign dmask     = data_r & mask;
  assign sh        = {lane_r, 3'b000};
  assign hs        = 6'd32 - {1'b0, sh};
  assign idx_hi    = idx_r + IDX_W'(1);
  assign lo_patch  = (rdata_r & ~(mask << sh)) | (dmask << sh);
  assign hi_patch  = (rdata_r & ~(mask >> hs)) | (dmask >> hs);
  assign rd_single = (rdata_r >> sh) & mask;
  assign rd_merged = ((lo_r >> sh) | (rdata_r << hs)) & mask;

  // store ports
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  logic [WORD_W-1:0] mem_wdata;
  logic              mem_re;
  logic [IDX_W-1:0]  mem_raddr;

  always_comb begin
    mem_we    = cmd.clr_wr | cmd.wr_lo | cmd.wr_hi;
    mem_waddr = idx_r;
    mem_wdata = lo_patch;
    if (cmd.clr_wr) begin
      mem_waddr = clr_cnt_r;
      mem_wdata = '0;
    end else if (cmd.wr_hi) begin
      mem_waddr = idx_hi;
      mem_wdata = hi_patch;
    end
    mem_re    = cmd.capture | cmd.rd_hi;
    mem_raddr = cmd.capture ? w_full[IDX_W-1:0] : idx_hi;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r    <= '0;
      clr_cnt_r <= '0;
    end else begin
      if (cfg_we) begin
        base_r <= cfg_wdata;
      end
      if (cmd.clr_wr) begin
        clr_cnt_r <= clr_cnt_r + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_r      <= in_action;
      size_r     <= in_size_code;
      lane_r     <= in_address[1:0];
      data_r     <= in_write_data;
      idx_r      <= w_full[IDX_W-1:0];
      straddle_r <= in_straddle;
      bad_r      <= in_bad;
    end
    if (cmd.rd_hi) begin
      lo_r <= rdata_r;
    end
    if (cmd.load_out) begin
      err_r <= bad_r;
      if (bad_r || (act_r == ACT_WRITE)) begin
        res_r <= '0;
      end else if (straddle_r) begin
        res_r <= rd_merged;
      end else begin
        res_r <= rd_single;
      end
    end
  end

  assign status.clr_last = (clr_cnt_r == IDX_W'(STORE_WORDS - 1));
  assign status.is_write = (act_r == ACT_WRITE);
  assign status.straddle = straddle_r;
  assign status.bad      = bad_r;

  assign out_read_data    = res_r;
  assign out_out_of_range = err_r;

endmodule

`default_nettype wire

/* rtl/core/uwsa_ctrl.sv */
// Controller: clearing pass, access sequencing and result valid.
`default_nettype none

module uwsa_ctrl
  import uwsa_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  wire logic         out_ready,
  input  wire uwsa_status_t status,
  output uwsa_cmd_t         cmd
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_LO    = 2'd2;
  localparam logic [1:0] ST_HI    = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (status.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_LO;
        end
      end
      ST_LO: begin
        if (status.bad || !status.straddle) begin
          // single word or rejected: finish once the result slot frees
          if (out_free) begin
            cmd.load_out = 1'b1;
            cmd.wr_lo    = status.is_write && !status.bad;
            state_nxt    = ST_IDLE;
          end
        end else begin
          cmd.wr_lo = status.is_write;
          cmd.rd_hi = 1'b1;
          state_nxt = ST_HI;
        end
      end
      ST_HI: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          cmd.wr_hi    = status.is_write;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

/* rtl/core/unaligned_word_store_access.sv */
// Byte, halfword and word access at any alignment onto a store of 32-bit words.
// Usage:
//   in_ch  : one access per beat (action, size_code, address, write_data).
//   out_ch : one result per access (read_data, out_of_range), in order.
//   cfg_we/cfg_wdata : base_address; write only while idle (not enforced).
// Sequence: a single-word or out-of-range access loads its result in ST_LO;
//   an access that straddles two words reads its high word there and loads
//   the result in ST_HI. One access is in flight at a time, so no new access
//   is taken before the last one has loaded its result; the word store's one
//   read and one write port are sequenced by the controller over those states.
// Reset: base_address goes to zero and a clearing pass zeroes the store one
//   word per cycle, up to the last word, with in_ch.ready low the whole time.
// Stall: a finished result sits in the output register; the next access is
//   taken meanwhile and runs up to its last step, then waits for out_ch.ready.
`default_nettype none

module unaligned_word_store_access
  import uwsa_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [WORD_W-1:0] cfg_wdata,
  uwsa_in_if.sink                in_ch,
  uwsa_out_if.source             out_ch
);

  uwsa_cmd_t    cmd;
  uwsa_status_t status;
  logic         in_ready;
  logic         out_valid;

  uwsa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  uwsa_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_action        (in_ch.action),
    .in_size_code     (in_ch.size_code),
    .in_address       (in_ch.address),
    .in_write_data    (in_ch.write_data),
    .cmd              (cmd),
    .status           (status),
    .out_read_data    (out_ch.read_data),
    .out_out_of_range (out_ch.out_of_range)
  );

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;

`ifndef SYNTHESIS
  // one access in flight: ready drops right after an accepted beat
  a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("second access accepted while one is in flight");

  // nothing accepted while the store is being cleared
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clr_wr |-> !in_ch.ready)
    else $error("input ready during clearing pass");

  // rejected accesses return zero data
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.out_of_range) |-> (out_ch.read_data == '0))
    else $error("out-of-range result carries data");

  // a result is loaded only when the output register is free or draining
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_ch.valid || out_ch.ready))
    else $error("result register overwritten before it was taken");
`endif

endmodule

`default_nettype wire
